### design/qdbd_pkg.sv
// Shared types and constants of the QOI decoder with box downscaler.
package qdbd_pkg;

    localparam int HASH_ENTRIES = 64;
    localparam int HASH_AW      = 6;
    localparam int COL_W        = 9;
    localparam int ROW_W        = 16;
    localparam int CNT_W        = 6;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE             = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_VISIBLE_ROW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_VISIBLE_ROW   = 3'd5;

    localparam logic [7:0] OP_RGB  = 8'hFE;
    localparam logic [7:0] OP_RGBA = 8'hFF;
    localparam logic [1:0] OP_INDEX = 2'd0;
    localparam logic [1:0] OP_DIFF  = 2'd1;
    localparam logic [1:0] OP_LUMA  = 2'd2;
    localparam logic [1:0] OP_RUN   = 2'd3;

    localparam logic [7:0] SNAP_LEVEL = 8'd220;

    typedef struct packed {
        logic [COL_W-1:0] image_width;
        logic [ROW_W-1:0] image_height;
        logic [4:0]       scale;
        logic [COL_W-1:0] visible_width;
        logic [ROW_W-1:0] first_visible_row;
        logic [ROW_W-1:0] end_visible_row;
    } t_cfg;

    // one queue entry: a decoded pixel repeated cnt times, or a new-image marker
    typedef struct packed {
        logic             start;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [CNT_W-1:0] cnt;
    } t_pix_cmd;

endpackage

### design/qdbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qdbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/qdbd_queue.sv
// Small register queue between the chunk decoder and the downscaler.
module qdbd_queue
    import qdbd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_pix_cmd i_data,
    output logic     o_full,
    input  logic     i_pop,
    output t_pix_cmd o_data,
    output logic     o_empty
);
    localparam int AW = $clog2(DEPTH);

    t_pix_cmd         r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end
endmodule

### design/qdbd_front.sv
// Chunk decoder: takes stream bytes, keeps the colour hash and previous pixel.
module qdbd_front
    import qdbd_pkg::*;
#(
    parameter int MAX_WIDTH = 320
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_byte,
    output logic       o_push,
    output t_pix_cmd   o_cmd,
    input  logic       i_full
);
    localparam int TOT_W = COL_W + ROW_W;
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_EXEC = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]  r_state;
    logic        r_cmd;
    logic [7:0]  r_byte;
    logic [1:0]  r_phase;
    logic [31:0] r_gath;
    logic [1:0]  r_gcnt;
    logic [7:0]  r_pr, r_pg, r_pb, r_pa;
    logic [HASH_ENTRIES-1:0] r_hvalid;
    logic [TOT_W-1:0] r_done, r_total;
    t_pix_cmd    r_ent;

    logic [31:0] hash_rd, entry;
    logic        pix;
    logic [7:0]  nr, ng, nb, na, vg;
    logic [CNT_W-1:0] ncnt;
    logic [1:0]  n_phase, n_gcnt;
    logic [31:0] n_gath, gath2;
    logic [2:0]  gnext;
    logic [HASH_AW-1:0] hidx;
    logic        ignore;

    function automatic logic [HASH_AW-1:0] hash_of(input logic [7:0] r, g, b, a);
        hash_of = HASH_AW'(10'(r) * 10'd3 + 10'(g) * 10'd5 + 10'(b) * 10'd7
                          + 10'(a) * 10'd11);
    endfunction

    qdbd_ram #(.WIDTH(32), .DEPTH(HASH_ENTRIES)) u_hash (
        .i_clk   (i_clk),
        .i_wr_en (r_state == F_EXEC && !r_cmd && !ignore && pix),
        .i_waddr (hidx),
        .i_wdata ({nr, ng, nb, na}),
        .i_raddr (i_byte[HASH_AW-1:0]),
        .o_rdata (hash_rd)
    );

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH);
    assign o_cmd   = r_ent;

    assign ignore = (i_cfg.image_width == '0)
                 || (11'(i_cfg.image_width) > 11'(MAX_WIDTH))
                 || (i_cfg.image_height == '0)
                 || (r_done >= r_total);
    assign entry  = r_hvalid[r_byte[HASH_AW-1:0]] ? hash_rd : 32'd0;
    assign vg     = {2'b00, r_gath[5:0]} + 8'd224;
    assign gath2  = {r_gath[23:0], r_byte};
    assign gnext  = {1'b0, r_gcnt} + 3'd1;
    assign hidx   = hash_of(nr, ng, nb, na);

    always_comb begin
        pix     = 1'b0;
        nr      = r_pr;
        ng      = r_pg;
        nb      = r_pb;
        na      = r_pa;
        ncnt    = CNT_W'(1);
        n_phase = r_phase;
        n_gath  = r_gath;
        n_gcnt  = r_gcnt;
        unique case (r_phase)
            2'd0: begin
                if (r_byte == OP_RGB) begin
                    n_phase = 2'd2;
                    n_gath  = '0;
                    n_gcnt  = '0;
                end else if (r_byte == OP_RGBA) begin
                    n_phase = 2'd3;
                    n_gath  = '0;
                    n_gcnt  = '0;
                end else begin
                    unique case (r_byte[7:6])
                        OP_INDEX: begin
                            pix = 1'b1;
                            {nr, ng, nb, na} = entry;
                        end
                        OP_DIFF: begin
                            pix = 1'b1;
                            nr  = r_pr + {6'b0, r_byte[5:4]} - 8'd2;
                            ng  = r_pg + {6'b0, r_byte[3:2]} - 8'd2;
                            nb  = r_pb + {6'b0, r_byte[1:0]} - 8'd2;
                        end
                        OP_LUMA: begin
                            n_gath  = {24'b0, r_byte};
                            n_phase = 2'd1;
                        end
                        default: begin
                            pix  = 1'b1;
                            ncnt = r_byte[5:0] + CNT_W'(1);
                        end
                    endcase
                end
            end
            2'd1: begin
                pix     = 1'b1;
                nr      = r_pr + vg + {4'b0, r_byte[7:4]} + 8'd248;
                ng      = r_pg + vg;
                nb      = r_pb + vg + {4'b0, r_byte[3:0]} + 8'd248;
                n_phase = 2'd0;
            end
            default: begin
                n_gath = gath2;
                n_gcnt = gnext[1:0];
                if (gnext == ((r_phase == 2'd2) ? 3'd3 : 3'd4)) begin
                    pix     = 1'b1;
                    n_phase = 2'd0;
                    n_gcnt  = '0;
                    if (r_phase == 2'd2) begin
                        {nr, ng, nb} = gath2[23:0];
                        na = 8'd255;
                    end else begin
                        {nr, ng, nb, na} = gath2;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_total <= TOT_W'(i_cfg.image_width) * TOT_W'(i_cfg.image_height);
        if (r_state == F_IDLE) begin
            r_cmd  <= i_cmd;
            r_byte <= i_byte;
        end
        if (r_state == F_EXEC) begin
            r_ent.start <= r_cmd;
            r_ent.red   <= nr;
            r_ent.green <= ng;
            r_ent.blue  <= nb;
            r_ent.cnt   <= ncnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_phase  <= '0;
            r_gath   <= '0;
            r_gcnt   <= '0;
            r_pr     <= '0;
            r_pg     <= '0;
            r_pb     <= '0;
            r_pa     <= 8'd255;
            r_hvalid <= '0;
            r_done   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_state <= F_EXEC;
                    end
                end
                F_EXEC: begin
                    if (r_cmd) begin
                        r_phase  <= '0;
                        r_gath   <= '0;
                        r_gcnt   <= '0;
                        r_pr     <= '0;
                        r_pg     <= '0;
                        r_pb     <= '0;
                        r_pa     <= 8'd255;
                        r_hvalid <= '0;
                        r_done   <= '0;
                        r_state  <= F_PUSH;
                    end else if (ignore) begin
                        r_state <= F_IDLE;
                    end else begin
                        r_phase <= n_phase;
                        r_gath  <= n_gath;
                        r_gcnt  <= n_gcnt;
                        if (pix) begin
                            r_pr           <= nr;
                            r_pg           <= ng;
                            r_pb           <= nb;
                            r_pa           <= na;
                            r_hvalid[hidx] <= 1'b1;
                            r_done         <= r_done + TOT_W'(ncnt);
                            r_state        <= F_PUSH;
                        end else begin
                            r_state <= F_IDLE;
                        end
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

### design/qdbd_back.sv
// Downscaler: snaps near-white, sums boxes per output column, divides, emits RGB565.
module qdbd_back
    import qdbd_pkg::*;
#(
    parameter int MAX_WIDTH = 320
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_pix_cmd          i_cmd,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_pixel,
    output logic [COL_W-1:0]  o_column,
    output logic [ROW_W-1:0]  o_line,
    output logic              o_last
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_PIX   = 3'd1;
    localparam logic [2:0] B_ACC   = 3'd2;
    localparam logic [2:0] B_DIV   = 3'd3;
    localparam logic [2:0] B_EMIT  = 3'd4;
    localparam logic [2:0] B_FLUSH = 3'd5;

    logic [2:0]       r_state;
    logic [7:0]       r_r, r_g, r_b;
    logic [CNT_W-1:0] r_cnt;
    logic [COL_W-1:0] r_col, r_oc;
    logic [ROW_W-1:0] r_row, r_line;
    logic [3:0]       r_cib, r_rib, r_dcnt;
    logic             r_inr;
    logic [8:0]       r_rem [3];
    logic [15:0]      r_quo [3];
    logic [8:0]       r_dvs;
    logic [COL_W-1:0] r_res_col;
    logic [ROW_W-1:0] r_res_line;
    logic             r_hold_v;
    logic [15:0]      r_hold_px;
    logic [COL_W-1:0] r_hold_col;
    logic [ROW_W-1:0] r_hold_line;
    logic             r_out_v, r_out_last;
    logic [15:0]      r_out_px;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_line;

    logic [4:0]  s_eff;
    logic [3:0]  sm1;
    logic [47:0] rd, sums;
    logic        first, block_end, emit, out_free, adv, inr;
    logic [15:0] px, res_px;
    logic [9:0]  t [3];

    assign s_eff = (i_cfg.scale == '0) ? 5'd1 : (i_cfg.scale > 5'd16) ? 5'd16 : i_cfg.scale;
    assign sm1   = 4'(s_eff - 5'd1);

    qdbd_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_sums (
        .i_clk   (i_clk),
        .i_wr_en (r_state == B_ACC && r_inr),
        .i_waddr (AW'(r_oc)),
        .i_wdata (sums),
        .i_raddr (AW'(r_oc)),
        .o_rdata (rd)
    );

    assign inr = (r_oc < i_cfg.visible_width)
              && (11'(r_oc) < 11'(MAX_WIDTH))
              && (15'((10'(r_oc) + 10'd1) * 10'(s_eff)) <= 15'(i_cfg.image_width));
    assign first     = (r_rib == '0) && (r_cib == '0);
    assign sums      = first ? {8'b0, r_r, 8'b0, r_g, 8'b0, r_b}
                             : {rd[47:32] + 16'(r_r), rd[31:16] + 16'(r_g), rd[15:0] + 16'(r_b)};
    assign block_end = (r_rib == sm1) || (17'(r_row) + 17'd1 == 17'(i_cfg.image_height));
    assign emit      = r_inr && block_end && (r_cib == sm1)
                    && (r_line >= i_cfg.first_visible_row) && (r_line < i_cfg.end_visible_row);
    assign out_free  = !r_out_v || i_ready;
    assign px        = {r_quo[0][7:3], r_quo[1][7:2], r_quo[2][7:3]};
    assign res_px    = {px[7:0], px[15:8]};

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            t[c] = {r_rem[c], r_quo[c][15]};
        end
    end

    always_comb begin
        adv = 1'b0;
        unique case (r_state)
            B_ACC:  adv = !emit;
            B_EMIT: adv = !r_hold_v || out_free;
            default: adv = 1'b0;
        endcase
    end

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign o_valid  = r_out_v;
    assign o_pixel  = r_out_px;
    assign o_column = r_out_col;
    assign o_line   = r_out_line;
    assign o_last   = r_out_last;

    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && !i_empty) begin
            if (i_cmd.red >= SNAP_LEVEL && i_cmd.green >= SNAP_LEVEL
                && i_cmd.blue >= SNAP_LEVEL) begin
                r_r <= 8'd255;
                r_g <= 8'd255;
                r_b <= 8'd255;
            end else begin
                r_r <= i_cmd.red;
                r_g <= i_cmd.green;
                r_b <= i_cmd.blue;
            end
        end
        if (r_state == B_PIX) begin
            r_inr <= inr;
        end
        if (r_state == B_ACC && emit) begin
            r_rem[0]   <= '0;
            r_rem[1]   <= '0;
            r_rem[2]   <= '0;
            r_quo[0]   <= sums[47:32];
            r_quo[1]   <= sums[31:16];
            r_quo[2]   <= sums[15:0];
            r_dvs      <= (9'(r_rib) + 9'd1) * 9'(s_eff);
            r_res_col  <= r_oc;
            r_res_line <= r_line;
        end
        if (r_state == B_DIV) begin
            for (int c = 0; c < 3; c++) begin
                if (t[c] >= {1'b0, r_dvs}) begin
                    r_rem[c] <= 9'(t[c] - {1'b0, r_dvs});
                    r_quo[c] <= {r_quo[c][14:0], 1'b1};
                end else begin
                    r_rem[c] <= t[c][8:0];
                    r_quo[c] <= {r_quo[c][14:0], 1'b0};
                end
            end
        end
        if (r_state == B_EMIT && adv) begin
            r_hold_px   <= res_px;
            r_hold_col  <= r_res_col;
            r_hold_line <= r_res_line;
        end
        if ((r_state == B_EMIT || r_state == B_FLUSH) && r_hold_v && out_free) begin
            r_out_px   <= r_hold_px;
            r_out_col  <= r_hold_col;
            r_out_line <= r_hold_line;
            r_out_last <= (r_state == B_FLUSH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_cnt    <= '0;
            r_col    <= '0;
            r_oc     <= '0;
            r_row    <= '0;
            r_line   <= '0;
            r_cib    <= '0;
            r_rib    <= '0;
            r_dcnt   <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            if ((r_state == B_EMIT || r_state == B_FLUSH) && r_hold_v && out_free) begin
                r_out_v <= 1'b1;
            end
            if (adv) begin
                if (17'(r_col) + 17'd1 >= 17'(i_cfg.image_width)) begin
                    r_col <= '0;
                    r_cib <= '0;
                    r_oc  <= '0;
                    r_row <= r_row + 1'b1;
                    if (r_rib == sm1) begin
                        r_rib  <= '0;
                        r_line <= r_line + 1'b1;
                    end else begin
                        r_rib <= r_rib + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                    if (r_cib == sm1) begin
                        r_cib <= '0;
                        r_oc  <= r_oc + 1'b1;
                    end else begin
                        r_cib <= r_cib + 1'b1;
                    end
                end
                r_cnt   <= r_cnt - 1'b1;
                r_state <= (r_cnt == CNT_W'(1)) ? B_FLUSH : B_PIX;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        if (i_cmd.start) begin
                            r_col  <= '0;
                            r_oc   <= '0;
                            r_row  <= '0;
                            r_line <= '0;
                            r_cib  <= '0;
                            r_rib  <= '0;
                        end else begin
                            r_cnt   <= i_cmd.cnt;
                            r_state <= B_PIX;
                        end
                    end
                end
                B_PIX: begin
                    r_state <= (r_row >= i_cfg.image_height) ? B_FLUSH : B_ACC;
                end
                B_ACC: begin
                    if (emit) begin
                        r_dcnt  <= '0;
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 4'd15) begin
                        r_state <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if (adv) begin
                        r_hold_v <= 1'b1;
                    end
                end
                B_FLUSH: begin
                    if (!r_hold_v) begin
                        r_state <= B_IDLE;
                    end else if (out_free) begin
                        r_hold_v <= 1'b0;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

### design/qoi_decoder_box_downscaler_top.sv
// Top level: QOI chunk decoder, pixel queue and box downscaler.
//
// Input stream: one chunk byte per transfer on s_axis_tdata; s_axis_tuser high
// marks a start-of-image command that clears the decoder and source position.
// Output stream: one transfer per finished visible box, tdata holds the
// byte-swapped RGB565 pixel, output column and output line; tlast marks the
// final result caused by one input byte.
// Configuration: i_cfg_index/i_cfg_data write one register per transfer;
// writes are taken at any time, i_cfg_index above 5 is dropped.
// Flow: the decoder accepts a byte, decodes it and, when it yields a pixel,
// pushes the entry while the queue has room; it takes no new byte until then.
// The downscaler handles each source pixel in a position and an accumulate step,
// with a pop and a flush step per pixel entry, and runs a 16-step divider over
// the three channels for each output pixel before it emits the result.
// A result passes through the hold register into the output register once the
// next result or the end of its byte is known. Reset clears all control
// state and the hash valid bits; no clearing pass is needed. When
// m_axis_tready is low the downscaler holds up to two results (output and
// hold registers) and then stalls; the 4-entry queue lets the decoder keep
// accepting.
module qoi_decoder_box_downscaler_top
    import qdbd_pkg::*;
#(
    parameter int MAX_WIDTH = 320
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [7:0] data_byte
    input  logic                  s_axis_tuser,  // [0] command
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,  // [15:0] pixel_565, [24:16] out_column,
                                                 // [40:25] out_line, rest zero
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_cfg             r_cfg;
    logic             push, pop, full, empty;
    t_pix_cmd         push_cmd, pop_cmd;
    logic [15:0]      pixel;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] line;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width       <= COL_W'(1);
            r_cfg.image_height      <= ROW_W'(1);
            r_cfg.scale             <= 5'd1;
            r_cfg.visible_width     <= COL_W'(320);
            r_cfg.first_visible_row <= '0;
            r_cfg.end_visible_row   <= ROW_W'(65535);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:       r_cfg.image_width       <= i_cfg_data[COL_W-1:0];
                CFG_IMAGE_HEIGHT:      r_cfg.image_height      <= i_cfg_data;
                CFG_SCALE:             r_cfg.scale             <= i_cfg_data[4:0];
                CFG_VISIBLE_WIDTH:     r_cfg.visible_width     <= i_cfg_data[COL_W-1:0];
                CFG_FIRST_VISIBLE_ROW: r_cfg.first_visible_row <= i_cfg_data;
                CFG_END_VISIBLE_ROW:   r_cfg.end_visible_row   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qdbd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (s_axis_tuser),
        .i_byte  (s_axis_tdata),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (full)
    );

    qdbd_queue #(.DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_empty (empty)
    );

    qdbd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cmd    (pop_cmd),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_pixel  (pixel),
        .o_column (column),
        .o_line   (line),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, line, column, pixel};
endmodule

### design/qdbd_checker.sv
// Port-level checks of the top level, bound to every instance.
module qdbd_checker #(
    parameter int MAX_WIDTH = 320
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        o_cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("output transfer changed while stalled");

    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[24:16]) < MAX_WIDTH))
        else $error("output column beyond sum buffer");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:41] == 7'd0)
        else $error("tdata padding not zero");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");
endmodule

bind qoi_decoder_box_downscaler_top qdbd_checker #(.MAX_WIDTH(MAX_WIDTH)) u_qdbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .o_cfg_ready   (o_cfg_ready)
);

### tb/tb_top.sv
// Self-checking testbench for the QOI decoder with box downscaler, predicted per input byte.
module tb_top;
    import qdbd_pkg::*;

    typedef enum int {PH_OP = 0, PH_LUMA = 1, PH_RGB = 2, PH_RGBA = 3} parse_t;

    typedef struct {
        bit       cmd;
        bit [7:0] data;
        bit       drain;
    } chunk_item_t;

    typedef struct {
        logic [15:0] px;
        logic [8:0]  col;
        logic [15:0] line;
        logic        last;
    } box_pixel_t;

    localparam int SRC_MAX_W = 320;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [47:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    qoi_decoder_box_downscaler_top dut (.*);

    chunk_item_t chunk_q[$];
    box_pixel_t  box_q[$];
    int errors;
    bit in_taken, out_taken, draining, hold_req;
    int send_gap, recv_gap, hold_cnt;

    // predictor state
    int cfg_w, cfg_h, cfg_scale, cfg_vis, cfg_first, cfg_end;
    bit [31:0] hash_tbl[0:63];
    int prev_r, prev_g, prev_b, prev_a;
    int run_left, gath_cnt, src_col, src_row;
    bit [31:0] gath;
    parse_t phase;
    bit [15:0] col_sums[0:SRC_MAX_W*3-1];

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 4000000);
        $display("TB_ERROR");
        $finish;
    end

    task automatic clear_decoder();
        foreach (hash_tbl[i]) hash_tbl[i] = '0;
        prev_r = 0; prev_g = 0; prev_b = 0; prev_a = 255;
        run_left = 0; phase = PH_OP; gath = 0; gath_cnt = 0;
        src_col = 0; src_row = 0;
    endtask

    task automatic set_reg(input int idx, input int val);
        case (idx)
            CFG_IMAGE_WIDTH:       cfg_w = val & 9'h1FF;
            CFG_IMAGE_HEIGHT:      cfg_h = val & 16'hFFFF;
            CFG_SCALE:             cfg_scale = val & 5'h1F;
            CFG_VISIBLE_WIDTH:     cfg_vis = val & 9'h1FF;
            CFG_FIRST_VISIBLE_ROW: cfg_first = val & 16'hFFFF;
            CFG_END_VISIBLE_ROW:   cfg_end = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic box_accumulate(input int r, input int g, input int b, inout int n);
        int s, outw, col, row, rib, oc, ci, cnt, rv, gv, bv, line;
        bit blk_end;
        bit [15:0] px;
        box_pixel_t e;
        col = src_col;
        row = src_row;
        if (row >= cfg_h) return;
        s = cfg_scale;
        if (s < 1) s = 1;
        if (s > 16) s = 16;
        if (r >= SNAP_LEVEL && g >= SNAP_LEVEL && b >= SNAP_LEVEL) begin
            r = 255; g = 255; b = 255;
        end
        outw = cfg_w / s;
        if (outw > cfg_vis) outw = cfg_vis;
        rib = row % s;
        blk_end = (rib == s - 1) || (row + 1 == cfg_h);
        oc = col / s;
        if (oc < outw && oc < SRC_MAX_W) begin
            ci = oc * 3;
            if (rib == 0 && col % s == 0) begin
                col_sums[ci] = r; col_sums[ci+1] = g; col_sums[ci+2] = b;
            end else begin
                col_sums[ci] = col_sums[ci] + r;
                col_sums[ci+1] = col_sums[ci+1] + g;
                col_sums[ci+2] = col_sums[ci+2] + b;
            end
            if (blk_end && col % s == s - 1) begin
                line = row / s;
                if (line >= cfg_first && line < cfg_end) begin
                    cnt = (rib + 1) * s;
                    rv = col_sums[ci] / cnt;
                    gv = col_sums[ci+1] / cnt;
                    bv = col_sums[ci+2] / cnt;
                    px = ((rv >> 3) << 11) | ((gv >> 2) << 5) | (bv >> 3);
                    e.px = {px[7:0], px[15:8]};
                    e.col = oc;
                    e.line = line;
                    e.last = 0;
                    box_q.push_back(e);
                    n++;
                end
            end
        end
        if (col + 1 >= cfg_w) begin
            src_col = 0;
            src_row = (row + 1) & 16'hFFFF;
        end else begin
            src_col = col + 1;
        end
    endtask

    task automatic decode_byte(input bit cmd, input bit [7:0] d);
        int r, g, b, a, n, vg;
        r = prev_r; g = prev_g; b = prev_b; a = prev_a;
        n = 0;
        if (cmd) begin
            clear_decoder();
            return;
        end
        if (cfg_w == 0 || cfg_w > SRC_MAX_W || cfg_h == 0) return;
        if (src_row >= cfg_h) return;
        if (phase == PH_OP) begin
            if (d == OP_RGB) begin
                phase = PH_RGB; gath = 0; gath_cnt = 0; return;
            end
            if (d == OP_RGBA) begin
                phase = PH_RGBA; gath = 0; gath_cnt = 0; return;
            end
            case (d[7:6])
                OP_INDEX: begin
                    r = hash_tbl[d[5:0]][31:24]; g = hash_tbl[d[5:0]][23:16];
                    b = hash_tbl[d[5:0]][15:8];  a = hash_tbl[d[5:0]][7:0];
                end
                OP_DIFF: begin
                    r = (r + d[5:4] + 254) & 255;
                    g = (g + d[3:2] + 254) & 255;
                    b = (b + d[1:0] + 254) & 255;
                end
                OP_LUMA: begin
                    gath = d; phase = PH_LUMA; return;
                end
                default: run_left = d[5:0];
            endcase
        end else if (phase == PH_LUMA) begin
            vg = (gath[5:0] + 224) & 255;
            r = (r + vg + d[7:4] + 248) & 255;
            g = (g + vg) & 255;
            b = (b + vg + d[3:0] + 248) & 255;
            phase = PH_OP;
        end else begin
            gath = (gath << 8) | d;
            gath_cnt++;
            if (gath_cnt < ((phase == PH_RGB) ? 3 : 4)) return;
            if (phase == PH_RGB) begin
                r = gath[23:16]; g = gath[15:8]; b = gath[7:0]; a = 255;
            end else begin
                r = gath[31:24]; g = gath[23:16]; b = gath[15:8]; a = gath[7:0];
            end
            phase = PH_OP;
            gath_cnt = 0;
        end
        hash_tbl[(r * 3 + g * 5 + b * 7 + a * 11) & 63] = {r[7:0], g[7:0], b[7:0], a[7:0]};
        prev_r = r; prev_g = g; prev_b = b; prev_a = a;
        box_accumulate(r, g, b, n);
        while (run_left > 0) begin
            run_left--;
            box_accumulate(r, g, b, n);
        end
        if (n > 0) box_q[box_q.size()-1].last = 1;
    endtask

    // monitor
    always @(posedge i_clk) begin
        box_pixel_t e;
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_taken = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (in_taken) decode_byte(s_axis_tuser, s_axis_tdata);
        if (out_taken) begin
            if (box_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected transfer: %h last %b",
                                           m_axis_tdata, m_axis_tlast);
            end else begin
                e = box_q.pop_front();
                if (m_axis_tdata[15:0] !== e.px || m_axis_tdata[24:16] !== e.col ||
                    m_axis_tdata[40:25] !== e.line || m_axis_tlast !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp px %h col %0d line %0d last %b, got px %h col %0d line %0d last %b",
                                 e.px, e.col, e.line, e.last, m_axis_tdata[15:0],
                                 m_axis_tdata[24:16], m_axis_tdata[40:25], m_axis_tlast);
                end
            end
        end
    end

    // input driver
    always @(negedge i_clk) begin
        bit v;
        chunk_item_t it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            send_gap = 0;
        end else begin
            v = s_axis_tvalid;
            if (v && in_taken) v = 0;
            if (!v) begin
                if (draining) begin
                    if (box_q.size() == 0) draining = 0;
                end else if (send_gap > 0) begin
                    send_gap--;
                end else if (chunk_q.size() > 0) begin
                    it = chunk_q.pop_front();
                    if (it.drain) begin
                        draining = 1;
                    end else begin
                        v = 1;
                        s_axis_tdata <= it.data;
                        s_axis_tuser <= it.cmd;
                        send_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
                    end
                end
            end
            s_axis_tvalid <= v;
        end
    end

    // output receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 0;
            recv_gap = 0;
        end else if (hold_req) begin
            m_axis_tready <= 0;
            if (hold_cnt < 400) begin
                hold_cnt++;
            end else begin
                hold_cnt = 0;
                hold_req = 0;
            end
        end else begin
            if (out_taken) recv_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
            if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    task automatic write_reg(input int idx, input int val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic configure(input int w, input int h, input int s, input int vis,
                             input int first, input int last_row);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_SCALE, s);
        write_reg(CFG_VISIBLE_WIDTH, vis);
        write_reg(CFG_FIRST_VISIBLE_ROW, first);
        write_reg(CFG_END_VISIBLE_ROW, last_row);
    endtask

    task automatic put_byte(input bit cmd, input int d);
        chunk_item_t it;
        it.cmd = cmd;
        it.data = d;
        it.drain = 0;
        chunk_q.push_back(it);
    endtask

    function automatic int pick_chan();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(215, 255) : $urandom_range(0, 255);
    endfunction

    // well-formed op stream with random content, some noise; returns bytes queued
    task automatic gen_image(input int npix, input int budget, input bit noisy, output int used);
        int px, k, i;
        px = 0;
        used = 1;
        put_byte(1, $urandom_range(0, 255));
        while (px < npix) begin
            k = (used >= budget) ? 9 : $urandom_range(0, 10);
            if (noisy && $urandom_range(0, 14) == 0) begin
                put_byte($urandom_range(0, 7) == 0, $urandom_range(0, 255));
                used++;
            end
            case (k)
                0: begin
                    put_byte(0, OP_RGB);
                    for (i = 0; i < 3; i++) put_byte(0, pick_chan());
                    used += 4; px++;
                end
                1: begin
                    put_byte(0, OP_RGBA);
                    for (i = 0; i < 4; i++) put_byte(0, pick_chan());
                    used += 5; px++;
                end
                2: begin put_byte(0, $urandom_range(0, 63)); used++; px++; end
                3: begin put_byte(0, 8'h40 | $urandom_range(0, 63)); used++; px++; end
                4: begin
                    put_byte(0, 8'h80 | $urandom_range(0, 63));
                    put_byte(0, $urandom_range(0, 255));
                    used += 2; px++;
                end
                default: begin
                    i = (used >= budget) ? 61 : $urandom_range(0, 61);
                    put_byte(0, 8'hC0 | i);
                    used++; px += i + 1;
                end
            endcase
        end
        for (i = $urandom_range(0, 2); i > 0; i--) begin
            put_byte(0, $urandom_range(0, 255));
            used++;
        end
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk);
        while (chunk_q.size() != 0 || s_axis_tvalid || draining || box_q.size() != 0);
        repeat (400) @(posedge i_clk);
    endtask

    initial begin
        int p, used, rand_items, w, h, s;
        chunk_item_t mark;
        errors = 0;
        draining = 0; hold_req = 0; hold_cnt = 0;
        in_taken = 0; out_taken = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
        m_axis_tready = 0;
        i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        cfg_w = 1; cfg_h = 1; cfg_scale = 1; cfg_vis = 320; cfg_first = 0; cfg_end = 65535;
        clear_decoder();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: every op, snap at exactly 220, zero hash read, run past image end
        configure(4, 3, 2, 320, 0, 65535);
        put_byte(1, 8'h00);
        put_byte(0, OP_RGB); put_byte(0, 8'hFF); put_byte(0, 8'h00); put_byte(0, 8'h80);
        put_byte(0, OP_RGBA); put_byte(0, 220); put_byte(0, 220); put_byte(0, 220);
        put_byte(0, 8'h10);
        put_byte(0, 8'h32);
        put_byte(0, 8'h00);
        put_byte(0, 8'h40);
        put_byte(0, 8'h7F);
        put_byte(0, 8'h80); put_byte(0, 8'h00);
        put_byte(0, 8'hBF); put_byte(0, 8'hFF);
        put_byte(0, 8'hC0);
        put_byte(0, 8'hFD);
        put_byte(0, 8'h12);
        wait_quiet();

        rand_items = 0;
        p = 0;
        while (rand_items < 330) begin
            case (p)
                0: begin
                    configure(320, 16, 16, 320, 0, 65535);
                    hold_req = 1;
                    gen_image(320 * 16, 30, 0, used);
                end
                1: begin
                    configure(1, 1, 1, 0, 65535, 65535);
                    gen_image(1, 10, 1, used);
                end
                2: begin
                    configure(7, 65535, 3, 2, 1, 3);
                    gen_image(150, 25, 1, used);
                end
                3: begin
                    configure(20, 5, 16, 320, 0, 65535);
                    gen_image(50, 20, 0, used);
                    mark.drain = 1; mark.cmd = 0; mark.data = 0;
                    chunk_q.push_back(mark);
                    gen_image(100, 20, 0, p);
                    used += p;
                    p = 3;
                end
                4: begin
                    configure(9, 4, 1, 320, 0, 0);
                    gen_image(36, 20, 1, used);
                end
                default: begin
                    w = $urandom_range(1, 24);
                    h = $urandom_range(1, 12);
                    s = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
                    configure(w, h, s, $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : 320,
                              $urandom_range(0, 2), $urandom_range(0, 1) ? 65535 : $urandom_range(0, 6));
                    gen_image(w * h, 40, $urandom_range(0, 2) == 0, used);
                end
            endcase
            rand_items += used;
            p++;
            wait_quiet();
        end

        if (errors == 0 && box_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
